FILE: rtl/okpp_pkg.sv
package okpp_pkg;

  localparam int PACKET_LENGTH_BITS_DEF = 32;
  localparam int SECONDS_PER_DAY = 24 * 3600;

  // tag byte fields
  localparam logic [7:0] TAG_VALID_BIT = 8'h80;
  localparam logic [7:0] TAG_NEW_FMT_BIT = 8'h40;
  localparam logic [1:0] LEN_TYPE_TO_END = 2'd3;

  // packet kinds of interest
  localparam logic [3:0] PKT_SIGNATURE = 4'd2;
  localparam logic [3:0] PKT_SECRET_KEY = 4'd5;
  localparam logic [3:0] PKT_PUBLIC_KEY = 4'd6;

  // key packet versions
  localparam logic [7:0] KEY_V3 = 8'd3;
  localparam logic [7:0] KEY_V4 = 8'd4;

  // algorithm bytes
  localparam logic [7:0] ALG_BYTE_RSA = 8'd1;
  localparam logic [7:0] ALG_BYTE_RSA_SIGN = 8'd3;
  localparam logic [7:0] ALG_BYTE_DSA = 8'd17;

  localparam logic [7:0] S2K_SPECIFIER = 8'd255;
  localparam logic [7:0] S2K_PLAIN = 8'd0;
  localparam logic [7:0] SYM_ALG_LIMIT = 8'd11;
  localparam logic [7:0] SIG_V3 = 8'd3;
  localparam logic [7:0] SIG_V3_HASHED_LEN = 8'd5;

  localparam logic [2:0] MPI_MODULUS = 3'd0;
  localparam logic [2:0] MPI_EXPONENT = 3'd1;
  localparam logic [2:0] MPI_PRIV_EXP = 3'd2;
  localparam logic [2:0] MPI_LAST = 3'd4;

  typedef enum logic [3:0] {
    PH_TAG,
    PH_LEN,
    PH_SKIP,
    PH_PK_VER,
    PH_PK_TIME,
    PH_PK_DAYS,
    PH_PK_ALG,
    PH_MPI_LEN,
    PH_MPI_DATA,
    PH_S2K,
    PH_SIG_VER,
    PH_SIG_SIZE,
    PH_SIG_TYPE,
    PH_SIG_TIME
  } phase_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_BAD_TAG,
    ST_NEW_FORMAT,
    ST_VERSION,
    ST_DSA,
    ST_OTHER_ALG,
    ST_S2K_SPEC,
    ST_BAD_SYM_ALG,
    ST_ENCRYPTED,
    ST_SIG_SIZE,
    ST_TRUNCATED
  } status_t;

  typedef enum logic [1:0] {
    KALG_NONE,
    KALG_RSA,
    KALG_DSA
  } key_alg_t;

  typedef struct packed {
    logic        mpi_byte_valid;
    logic [2:0]  mpi_field;
    logic [7:0]  mpi_data;
    logic        file_done;
    status_t     parse_status;
    logic [2:0]  key_version;
    logic [31:0] created_time;
    logic [33:0] valid_until;
    key_alg_t    key_algorithm;
  } result_t;

endpackage

FILE: rtl/openpgp_key_packet_parser_unit.sv
// A byte is held in the input register; the core's result for it is captured in the output
// register in the same cycle as the parser state update, once the output slot is free.
// Throughput: one byte per cycle unless the output stalls, set by the parser state update.
// Reset: rst is synchronous, active high; clears both stages, the parser state and the
// key_file_mode register. The configuration channel is always ready.
module openpgp_key_packet_parser_unit #(
  parameter int PACKET_LENGTH_BITS = okpp_pkg::PACKET_LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,       // key_file_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] file_byte
  input  logic        s_axis_tlast,   // last_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] mpi_data, [11:8] parse_status, [14:12] key_version, [46:15] created_time,
  // [80:47] valid_until, [82:81] key_algorithm, [87:83] zero
  output logic [87:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,   // [0] mpi_byte_valid, [3:1] mpi_field
  output logic        m_axis_tlast    // file_done
);
  import okpp_pkg::*;

  logic       key_file_mode;
  logic       in_valid;
  logic [7:0] in_byte;
  logic       in_last;
  logic       advance;
  result_t    res;

  assign cfg_ready     = 1'b1;
  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_file_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      key_file_mode <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
      in_last <= s_axis_tlast;
    end
  end

  okpp_core #(
    .PACKET_LENGTH_BITS(PACKET_LENGTH_BITS)
  ) u_core (
    .clk          (clk),
    .rst          (rst),
    .step_en      (advance),
    .step_byte    (in_byte),
    .step_last    (in_last),
    .key_file_mode(key_file_mode),
    .res          (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {5'd0, res.key_algorithm, res.valid_until, res.created_time,
                       res.key_version, res.parse_status, res.mpi_data};
      m_axis_tuser <= {res.mpi_field, res.mpi_byte_valid};
      m_axis_tlast <= res.file_done;
    end
  end

  a_summary_only_at_end: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[82:8] == 75'd0)
    else $error("file summary present on a non-final result");

  a_mpi_fields_gated: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tuser[3:1] == 3'd0 &&
                                          m_axis_tdata[7:0] == 8'd0)
    else $error("MPI payload present without MPI flag");

endmodule

FILE: rtl/okpp_core.sv
module okpp_core #(
  parameter int PACKET_LENGTH_BITS = okpp_pkg::PACKET_LENGTH_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             step_en,
  input  logic [7:0]       step_byte,
  input  logic             step_last,
  input  logic             key_file_mode,
  output okpp_pkg::result_t res
);
  import okpp_pkg::*;

  localparam logic [32:0] MAX_LEN = (33'd1 << PACKET_LENGTH_BITS) - 33'd1;

  phase_t                          phase, phase_next;
  logic [2:0]                      fbc, fbc_next;
  logic [PACKET_LENGTH_BITS-1:0]   remaining, remaining_next;
  logic                            run_to_end, run_to_end_next;
  logic [31:0]                     acc, acc_next;
  logic [3:0]                      kind, kind_next;
  logic [2:0]                      version_seen, version_seen_next;
  logic [31:0]                     created, created_next;
  logic [33:0]                     expiry_time, expiry_time_next;
  key_alg_t                        alg, alg_next;
  logic [2:0]                      mpi_index, mpi_index_next;
  logic [13:0]                     mpi_remaining, mpi_remaining_next;
  status_t                         err, err_next;

  logic [31:0] acc_shift;
  logic [2:0]  fbc_inc;
  logic [16:0] mpi_bits_rnd;
  logic [33:0] days_secs;
  logic [15:0] days;
  logic        check_end;
  status_t     final_err;
  phase_t      nam_phase;
  logic [2:0]  nam_index;
  logic        nam_begin;
  logic [13:0] mpi_rem_dec;

  function automatic phase_t body_phase(input logic [3:0] k, input logic mode);
    phase_t p;
    p = PH_SKIP;
    if (!mode) begin
      if (k == PKT_PUBLIC_KEY) p = PH_PK_VER;
      else if (k == PKT_SIGNATURE) p = PH_SIG_VER;
    end else if (k == PKT_SECRET_KEY) begin
      p = PH_PK_VER;
    end
    return p;
  endfunction

  assign acc_shift    = {acc[23:0], step_byte};
  assign fbc_inc      = fbc + 3'd1;
  assign mpi_bits_rnd = {1'b0, acc_shift[15:0]} + 17'd7;
  assign days         = acc_shift[15:0];
  assign days_secs    = 34'(days) * 34'(SECONDS_PER_DAY);
  assign mpi_rem_dec  = mpi_remaining - 14'd1;

  // what follows a finished MPI
  always_comb begin
    nam_phase = PH_MPI_LEN;
    nam_index = mpi_index;
    nam_begin = 1'b0;
    if (mpi_index == MPI_EXPONENT) begin
      nam_phase = key_file_mode ? PH_S2K : PH_SKIP;
    end else if (mpi_index >= MPI_LAST) begin
      nam_phase = PH_SKIP;
    end else begin
      nam_index = mpi_index + 3'd1;
      nam_begin = 1'b1;
    end
  end

  always_comb begin
    phase_next         = phase;
    fbc_next           = fbc;
    remaining_next     = remaining;
    run_to_end_next    = run_to_end;
    acc_next           = acc;
    kind_next          = kind;
    version_seen_next  = version_seen;
    created_next       = created;
    expiry_time_next   = expiry_time;
    alg_next           = alg;
    mpi_index_next     = mpi_index;
    mpi_remaining_next = mpi_remaining;
    err_next           = err;
    check_end          = 1'b0;
    final_err          = ST_OK;
    res                = '0;

    if (step_en && err == ST_OK) begin
      unique case (phase)
        PH_TAG: begin
          if ((step_byte & TAG_VALID_BIT) == 8'd0) begin
            err_next = ST_BAD_TAG;
          end else if ((step_byte & TAG_NEW_FMT_BIT) != 8'd0) begin
            err_next = ST_NEW_FORMAT;
          end else begin
            kind_next      = step_byte[5:2];
            remaining_next = '0;
            if (step_byte[1:0] == LEN_TYPE_TO_END) begin
              run_to_end_next = 1'b1;
              phase_next      = body_phase(step_byte[5:2], key_file_mode);
            end else begin
              run_to_end_next = 1'b0;
              fbc_next        = (step_byte[1:0] == 2'd0) ? 3'd1 : {step_byte[1:0], 1'b0};
              acc_next        = '0;
              phase_next      = PH_LEN;
            end
          end
        end
        PH_LEN: begin
          acc_next = acc_shift;
          fbc_next = fbc - 3'd1;
          if (fbc == 3'd1) begin
            // lengths past the counter width saturate
            remaining_next = ({1'b0, acc_shift} > MAX_LEN) ? '1
                                                           : acc_shift[PACKET_LENGTH_BITS-1:0];
            phase_next     = body_phase(kind, key_file_mode);
            check_end      = 1'b1;
          end
        end
        default: begin
          check_end = 1'b1;
          if (!run_to_end && remaining != '0)
            remaining_next = remaining - PACKET_LENGTH_BITS'(1);
          unique case (phase)
            PH_PK_VER: begin
              if (step_byte < KEY_V3 || step_byte > KEY_V4) begin
                err_next = ST_VERSION;
              end else begin
                version_seen_next = step_byte[2:0];
                expiry_time_next  = '0;
                phase_next        = PH_PK_TIME;
                fbc_next          = '0;
                acc_next          = '0;
              end
            end
            PH_PK_TIME: begin
              acc_next = acc_shift;
              fbc_next = fbc_inc;
              if (fbc_inc == 3'd4) begin
                created_next = acc_shift;
                phase_next   = (version_seen == KEY_V3[2:0]) ? PH_PK_DAYS : PH_PK_ALG;
                fbc_next     = '0;
                acc_next     = '0;
              end
            end
            PH_PK_DAYS: begin
              acc_next = acc_shift;
              fbc_next = fbc_inc;
              if (fbc_inc == 3'd2) begin
                expiry_time_next = (days != 16'd0) ? ({2'b00, created} + days_secs) : '0;
                phase_next       = PH_PK_ALG;
              end
            end
            PH_PK_ALG: begin
              if (step_byte == ALG_BYTE_RSA || step_byte == ALG_BYTE_RSA_SIGN) begin
                alg_next       = KALG_RSA;
                mpi_index_next = MPI_MODULUS;
                phase_next     = PH_MPI_LEN;
                fbc_next       = '0;
                acc_next       = '0;
              end else if (step_byte == ALG_BYTE_DSA) begin
                alg_next = KALG_DSA;
                err_next = ST_DSA;
              end else begin
                alg_next = KALG_NONE;
                err_next = ST_OTHER_ALG;
              end
            end
            PH_MPI_LEN: begin
              acc_next = acc_shift;
              fbc_next = fbc_inc;
              if (fbc_inc == 3'd2) begin
                mpi_remaining_next = mpi_bits_rnd[16:3];
                if (mpi_bits_rnd[16:3] == 14'd0) begin
                  phase_next     = nam_phase;
                  mpi_index_next = nam_index;
                  if (nam_begin) begin
                    fbc_next = '0;
                    acc_next = '0;
                  end
                end else begin
                  phase_next = PH_MPI_DATA;
                end
              end
            end
            PH_MPI_DATA: begin
              res.mpi_byte_valid = 1'b1;
              res.mpi_field      = mpi_index;
              res.mpi_data       = step_byte;
              mpi_remaining_next = mpi_rem_dec;
              if (mpi_rem_dec == 14'd0) begin
                phase_next     = nam_phase;
                mpi_index_next = nam_index;
                if (nam_begin) begin
                  fbc_next = '0;
                  acc_next = '0;
                end
              end
            end
            PH_S2K: begin
              if (step_byte == S2K_SPECIFIER) begin
                err_next = ST_S2K_SPEC;
              end else if (step_byte >= SYM_ALG_LIMIT) begin
                err_next = ST_BAD_SYM_ALG;
              end else if (step_byte != S2K_PLAIN) begin
                err_next = ST_ENCRYPTED;
              end else begin
                mpi_index_next = MPI_PRIV_EXP;
                phase_next     = PH_MPI_LEN;
                fbc_next       = '0;
                acc_next       = '0;
              end
            end
            PH_SIG_VER: phase_next = (step_byte == SIG_V3) ? PH_SIG_SIZE : PH_SKIP;
            PH_SIG_SIZE: begin
              if (step_byte != SIG_V3_HASHED_LEN) err_next = ST_SIG_SIZE;
              else phase_next = PH_SIG_TYPE;
            end
            PH_SIG_TYPE: begin
              phase_next = PH_SIG_TIME;
              fbc_next   = '0;
              acc_next   = '0;
            end
            PH_SIG_TIME: begin
              fbc_next = fbc_inc;
              if (fbc_inc == 3'd4) phase_next = PH_SKIP;
            end
            default: ;
          endcase
        end
      endcase

      // end of a counted packet
      if (check_end && err_next == ST_OK && !run_to_end_next && remaining_next == '0) begin
        if (phase_next == PH_SKIP) phase_next = PH_TAG;
        else err_next = ST_TRUNCATED;
      end
    end

    if (step_en && step_last) begin
      final_err = err_next;
      if (err_next == ST_OK &&
          !(phase_next == PH_TAG || (run_to_end_next && phase_next == PH_SKIP)))
        final_err = ST_TRUNCATED;
      res.file_done     = 1'b1;
      res.parse_status  = final_err;
      res.key_version   = version_seen_next;
      res.created_time  = created_next;
      res.valid_until   = expiry_time_next;
      res.key_algorithm = alg_next;
      // next byte starts a new file
      phase_next         = PH_TAG;
      fbc_next           = '0;
      remaining_next     = '0;
      run_to_end_next    = 1'b0;
      acc_next           = '0;
      kind_next          = '0;
      version_seen_next  = '0;
      created_next       = '0;
      expiry_time_next   = '0;
      alg_next           = KALG_NONE;
      mpi_index_next     = '0;
      mpi_remaining_next = '0;
      err_next           = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_TAG;
      fbc           <= '0;
      remaining     <= '0;
      run_to_end    <= 1'b0;
      acc           <= '0;
      kind          <= '0;
      version_seen  <= '0;
      created       <= '0;
      expiry_time   <= '0;
      alg           <= KALG_NONE;
      mpi_index     <= '0;
      mpi_remaining <= '0;
      err           <= ST_OK;
    end else begin
      phase         <= phase_next;
      fbc           <= fbc_next;
      remaining     <= remaining_next;
      run_to_end    <= run_to_end_next;
      acc           <= acc_next;
      kind          <= kind_next;
      version_seen  <= version_seen_next;
      created       <= created_next;
      expiry_time   <= expiry_time_next;
      alg           <= alg_next;
      mpi_index     <= mpi_index_next;
      mpi_remaining <= mpi_remaining_next;
      err           <= err_next;
    end
  end

  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    err != ST_OK && !(step_en && step_last) |=> err == $past(err))
    else $error("latched error changed before end of file");

  a_mpi_rem_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_MPI_DATA |-> mpi_remaining != 14'd0)
    else $error("in MPI data with no bytes left");

  a_mpi_index_range: assert property (@(posedge clk) disable iff (rst)
    mpi_index <= MPI_LAST)
    else $error("MPI index out of range");

endmodule
